FILE: hdl/shs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, round constants and sigma functions of the SHA-256 hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

  // index 0 is H0 / working variable a
  typedef logic [7:0][31:0] hash_t;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;
  localparam logic [3:0]  LenHiWord  = 4'd14;
  localparam logic [3:0]  LenLoWord  = 4'd15;
  localparam logic [7:0]  PadMark    = 8'h80;

  localparam hash_t H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

FILE: hdl/shs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module shs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/shs_compress.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_compress
// One SHA-256 round per cycle. Message words 0..15 stream from the block
// RAM, later words come from a 16-word schedule window.
// ----------------------------------------------------------------------------
module shs_compress (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  shs_pkg::hash_t   h_i,
  input  logic [31:0]      rd_data_i,
  output logic [3:0]       rd_addr_o,
  output logic             done_o,
  output shs_pkg::hash_t   vars_o
);
  import shs_pkg::*;

  logic             run_q, done_q;
  logic [5:0]       r_q;
  hash_t            v_q, v_d;
  logic [15:0][31:0] win_q;
  logic [31:0]      w_sched, w_t, t1, t2, ch, maj;

  assign rd_addr_o = start_i ? 4'd0 : r_q[3:0] + 4'd1;
  assign w_sched   = small_sig1(win_q[14]) + win_q[9] + small_sig0(win_q[1]) + win_q[0];
  assign w_t       = (r_q[5:4] == 2'b00) ? rd_data_i : w_sched;

  always_comb begin
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1  = v_q[7] + big_sig1(v_q[4]) + ch + ROUND_K[r_q] + w_t;
    t2  = big_sig0(v_q[0]) + maj;
    v_d = {v_q[6], v_q[5], v_q[4], v_q[3] + t1, v_q[2], v_q[1], v_q[0], t1 + t2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      r_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        r_q   <= '0;
      end else if (run_q) begin
        r_q <= r_q + 6'd1;
        if (r_q == 6'(Rounds - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= h_i;
    end else if (run_q) begin
      v_q   <= v_d;
      win_q <= {w_t, win_q[15:1]};
    end
  end

  assign done_o = done_q;
  assign vars_o = v_q;

`ifndef SYNTHESIS
  a_no_start_while_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !run_q) else $error("compression restarted while running");
  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q) else $error("done while still running");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done longer than one cycle");
`endif

endmodule

FILE: hdl/sha256_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-stream SHA-256: block RAM, round unit and padding/output sequencer.
// ----------------------------------------------------------------------------
// A byte beat is packed into 32-bit words in a 16-word block RAM. Every 64th
// byte starts a compression: a start state primes the RAM read, the rounds
// run and the result is folded into the hash; no beat is taken meanwhile. A
// beat with tlast writes the padding one word per cycle up to word 15, runs
// one or two compressions, then presents the eight digest words, one per
// output beat, H0 first.
module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] msg_byte
  input  logic        s_axis_tuser_i,   // byte_valid
  input  logic        s_axis_tlast_i,   // end_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast_o    // last_word
);
  import shs_pkg::*;

  typedef enum logic [2:0] {ST_IN, ST_PAD, ST_START, ST_WAIT, ST_OUT} state_e;
  typedef enum logic [1:0] {AF_IN, AF_PAD1, AF_PAD2, AF_OUT} after_e;

  state_e      state_q;
  after_e      after_q;
  hash_t       h_q, vars;
  logic [5:0]  fill_q, fill_nxt;
  logic [31:0] word_q, word_nxt, pad_word;
  logic [63:0] bits_q;
  logic [3:0]  pad_idx_q, rd_addr;
  logic        pad_first_q, len_blk_q;
  logic [2:0]  out_idx_q;
  logic        out_valid_q, comp_done;
  logic        in_acc, ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata, ram_rdata;

  assign s_axis_tready_o = (state_q == ST_IN);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign word_nxt        = {word_q[23:0], s_axis_tdata_i};
  assign fill_nxt        = fill_q + 6'd1;

  always_comb begin
    case (fill_q[1:0])
      2'd0:    pad_word = {PadMark, 24'd0};
      2'd1:    pad_word = {word_q[7:0], PadMark, 16'd0};
      2'd2:    pad_word = {word_q[15:0], PadMark, 8'd0};
      default: pad_word = {word_q[23:0], PadMark};
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pad_idx_q;
    ram_wdata = '0;
    if (state_q == ST_PAD) begin
      ram_we = 1'b1;
      if (pad_first_q) begin
        ram_wdata = pad_word;
      end else if (len_blk_q && pad_idx_q == LenHiWord) begin
        ram_wdata = bits_q[63:32];
      end else if (len_blk_q && pad_idx_q == LenLoWord) begin
        ram_wdata = bits_q[31:0];
      end
    end else if (in_acc && s_axis_tuser_i && fill_q[1:0] == 2'd3) begin
      ram_we    = 1'b1;
      ram_waddr = fill_q[5:2];
      ram_wdata = word_nxt;
    end
  end

  shs_ram #(.Width(32), .Depth(BlockWords)) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  shs_compress u_compress (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == ST_START),
    .h_i       (h_q),
    .rd_data_i (ram_rdata),
    .rd_addr_o (rd_addr),
    .done_o    (comp_done),
    .vars_o    (vars)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IN;
      after_q     <= AF_IN;
      h_q         <= H_INIT;
      fill_q      <= '0;
      bits_q      <= '0;
      pad_idx_q   <= '0;
      pad_first_q <= 1'b0;
      len_blk_q   <= 1'b0;
      out_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IN: begin
          if (in_acc) begin
            if (s_axis_tuser_i) begin
              fill_q <= fill_nxt;
              bits_q <= bits_q + 64'd8;
            end
            if (s_axis_tuser_i && fill_q == 6'd63) begin
              state_q <= ST_START;
              after_q <= s_axis_tlast_i ? AF_PAD1 : AF_IN;
            end else if (s_axis_tlast_i) begin
              state_q     <= ST_PAD;
              pad_first_q <= 1'b1;
              if (s_axis_tuser_i) begin
                pad_idx_q <= fill_nxt[5:2];
                len_blk_q <= fill_nxt[5:2] < LenHiWord;
              end else begin
                pad_idx_q <= fill_q[5:2];
                len_blk_q <= fill_q[5:2] < LenHiWord;
              end
            end
          end
        end
        ST_PAD: begin
          pad_first_q <= 1'b0;
          pad_idx_q   <= pad_idx_q + 4'd1;
          if (pad_idx_q == LenLoWord) begin
            state_q <= ST_START;
            after_q <= len_blk_q ? AF_OUT : AF_PAD2;
          end
        end
        ST_START: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (comp_done) begin
            for (int i = 0; i < 8; i++) begin
              h_q[i] <= h_q[i] + vars[i];
            end
            case (after_q)
              AF_IN:   state_q <= ST_IN;
              AF_PAD1: begin
                state_q     <= ST_PAD;
                pad_idx_q   <= '0;
                pad_first_q <= 1'b1;
                len_blk_q   <= 1'b1;
              end
              AF_PAD2: begin
                state_q     <= ST_PAD;
                pad_idx_q   <= '0;
                pad_first_q <= 1'b0;
                len_blk_q   <= 1'b1;
              end
              default: begin
                state_q     <= ST_OUT;
                out_idx_q   <= '0;
                out_valid_q <= 1'b1;
              end
            endcase
          end
        end
        ST_OUT: begin
          if (out_valid_q && m_axis_tready_i) begin
            out_idx_q <= out_idx_q + 3'd1;
            if (out_idx_q == 3'd7) begin
              // restart for the next message
              out_valid_q <= 1'b0;
              state_q     <= ST_IN;
              h_q         <= H_INIT;
              fill_q      <= '0;
              bits_q      <= '0;
            end
          end
        end
        default: state_q <= ST_IN;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser_i) begin
      word_q <= word_nxt;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_idx_q, h_q[out_idx_q]};
  assign m_axis_tlast_o  = (out_idx_q == 3'd7);

`ifndef SYNTHESIS
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == ST_OUT) else $error("digest beat outside output phase");
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !out_valid_q) else $error("input ready while digest pending");
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    comp_done |-> state_q == ST_WAIT) else $error("compression done outside wait");
`endif

endmodule

FILE: tb/tb_sha256_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher
// Byte-stream SHA-256 check: beats carry message bytes with random idles and
// back-pressure; a local hash model predicts the eight digest beats of every
// message, and the monitor compares each output beat in order.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher;
  import shs_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } byte_beat_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  sha256_stream_hasher u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i, .s_axis_tlast_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tlast_o
  );

  // hasher model state
  logic [31:0] mdl_h [8];
  logic [7:0]  mdl_blk [64];
  int unsigned mdl_fill;
  logic [63:0] mdl_bits;

  byte_beat_t   pending_beats [$];
  digest_beat_t digest_q [$];
  int           errors = 0;
  bit           stim_done = 1'b0;
  bit           calm = 1'b0;     // no idling in the closing stretch
  bit           hold_tx = 1'b0;  // sender holds until the digest queue drains

  initial forever #2 clk_i = ~clk_i;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void mdl_compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int r = 0; r < 16; r++)
      w[r] = {mdl_blk[4*r], mdl_blk[4*r+1], mdl_blk[4*r+2], mdl_blk[4*r+3]};
    for (int r = 16; r < 64; r++)
      w[r] = (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7] +
             (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
    for (int i = 0; i < 8; i++) v[i] = mdl_h[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) mdl_h[i] += v[i];
  endfunction

  function automatic void mdl_restart();
    for (int i = 0; i < 8; i++) mdl_h[i] = H_INIT[i];
    for (int i = 0; i < 64; i++) mdl_blk[i] = '0;
    mdl_fill = 0;
    mdl_bits = '0;
  endfunction

  function automatic void predict_digest(byte_beat_t b);
    int unsigned pos;
    if (b.has_byte) begin
      mdl_blk[mdl_fill] = b.data;
      mdl_fill++;
      mdl_bits += 64'd8;
      if (mdl_fill == 64) begin
        mdl_compress();
        mdl_fill = 0;
      end
    end
    if (!b.eom) return;
    pos = mdl_fill;
    mdl_blk[pos++] = PadMark;
    if (pos > 56) begin
      while (pos < 64) mdl_blk[pos++] = '0;
      mdl_compress();
      pos = 0;
    end
    while (pos < 56) mdl_blk[pos++] = '0;
    for (int k = 0; k < 8; k++) mdl_blk[56+k] = mdl_bits[63-8*k -: 8];
    mdl_compress();
    for (int k = 0; k < 8; k++) digest_q.push_back('{mdl_h[k], 3'(k), k == 7});
    mdl_restart();
  endfunction

  function automatic void add_message(int len, bit noise, bit tail_byte);
    byte_beat_t b;
    for (int i = 0; i < len; i++) begin
      if (noise && $urandom_range(0, 7) == 0)
        pending_beats.push_back('{8'($urandom), 1'b0, 1'b0});
      b = '{8'($urandom), 1'b1, 1'b0};
      if (tail_byte && i == len - 1) b.eom = 1'b1;
      pending_beats.push_back(b);
    end
    if (!tail_byte || len == 0) pending_beats.push_back('{8'($urandom), 1'b0, 1'b1});
  endfunction

  // driver
  int tx_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (s_axis_tvalid_i) predict_digest({s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i});
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_beats.size() == 0 || (hold_tx && digest_q.size() != 0)) begin
          s_axis_tvalid_i <= 1'b0;
        end else begin
          {s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i} <= pending_beats.pop_front();
          s_axis_tvalid_i <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) tx_gap <= $urandom_range(1, 9);
        end
      end
    end
  end

  // monitor and back-pressure
  int rx_gap = 0;
  digest_beat_t got, want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = '{m_axis_tdata_o[31:0], m_axis_tdata_o[34:32], m_axis_tlast_o};
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest beat %h", $time, got);
          errors++;
        end else begin
          want = digest_q.pop_front();
          if (got.word !== want.word || got.idx !== want.idx || got.last !== want.last) begin
            $display("%0t: digest mismatch exp word %h idx %0d last %b, got %h %0d %b",
                     $time, want.word, want.idx, want.last, got.word, got.idx, got.last);
            errors++;
          end
        end
      end
      if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rx_gap <= $urandom_range(0, 8);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    int lens [] = '{0, 1, 55, 56, 63, 64, 119};
    mdl_restart();
    // directed: empty message, idle beat, boundary lengths, byte with end
    pending_beats.push_back('{8'hff, 1'b0, 1'b0});
    add_message(0, 1'b0, 1'b0);
    pending_beats.push_back('{8'h00, 1'b1, 1'b0});
    pending_beats.push_back('{8'hff, 1'b1, 1'b1});
    foreach (lens[i]) add_message(lens[i], 1'b0, 1'(i % 2));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_beats.size() == 0);
    // random messages, mostly short; hold the sender once until drained
    hold_tx = 1'b1;
    while (pending_beats.size() < 90) add_message(int'($urandom_range(0, 70)),
                                                 1'b1, 1'($urandom_range(0, 1)));
    wait (!s_axis_tvalid_i);
    wait (digest_q.size() == 0);
    hold_tx = 1'b0;
    wait (pending_beats.size() < 25);
    calm = 1'b1;
    wait (pending_beats.size() == 0 && !s_axis_tvalid_i && digest_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && digest_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #8ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: files.f
hdl/shs_pkg.sv
hdl/shs_ram.sv
hdl/shs_compress.sv
hdl/sha256_stream_hasher.sv
tb/tb_sha256_stream_hasher.sv
